@@ src/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants for the step sequencer tone block
// Field widths, command and register codes, the front-to-back command
// format, the modulo unit handshake and the note period table.
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

    localparam int MAX_STEPS   = 64;
    localparam int NOTE_COUNT  = 128;
    localparam int QUEUE_DEPTH = 2;

    localparam int FUNC_W     = 2;
    localparam int INDEX_W    = 6;
    localparam int NOTE_W     = 7;
    localparam int SAMPLE_W   = 16;
    localparam int SPS_W      = 24;
    localparam int SEQ_LEN_W  = 7;
    localparam int AMP_W      = 15;
    localparam int PERIOD_W   = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // command codes carried on func
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP     = 2'd3;

    localparam logic [SPS_W-1:0]     SPS_RESET     = 24'd6000;
    localparam logic [SEQ_LEN_W-1:0] SEQ_LEN_RESET = 7'd16;
    localparam logic                 LOOP_RESET    = 1'b1;
    localparam logic [AMP_W-1:0]     AMP_RESET     = 15'd3277;

    typedef struct packed {
        logic [FUNC_W-1:0]  op;
        logic [INDEX_W-1:0] index;
        logic [NOTE_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic                start;
        logic [SPS_W-1:0]    dividend;
        logic [PERIOD_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic                done;
        logic [PERIOD_W-1:0] remainder;
    } mod_rsp_t;

    // floor(48000 / (440 * 2^((n-69)/12))) in samples, note 0..127
    localparam logic [PERIOD_W-1:0] PERIOD_ROM [NOTE_COUNT] = '{
        5870, 5541, 5230, 4936, 4659, 4398, 4151, 3918, 3698,
        3490, 3294, 3110, 2935, 2770, 2615, 2468, 2329, 2199, 2075, 1959, 1849,
        1745, 1647, 1555, 1467, 1385, 1307, 1234, 1164, 1099, 1037,  979,  924,
         872,  823,  777,  733,  692,  653,  617,  582,  549,  518,  489,  462,
         436,  411,  388,  366,  346,  326,  308,  291,  274,  259,  244,  231,
         218,  205,  194,  183,  173,  163,  154,  145,  137,  129,  122,  115,
         109,  102,   97,   91,   86,   81,   77,   72,   68,   64,   61,   57,
          54,   51,   48,   45,   43,   40,   38,   36,   34,   32,   30,   28,
          27,   25,   24,   22,   21,   20,   19,   18,   17,   16,   15,   14,
          13,   12,   12,   11,   10,   10,    9,    9,    8,    8,    7,    7,
           6,    6,    6,    5,    5,    5,    4,    4,    4,    4,    3
    };

endpackage

`default_nettype wire

@@ src/sst_front.sv @@
// ----------------------------------------------------------------------------
// sst_front: input stage
// Takes input beats, drops note writes outside the step store and holds
// one classified command until the queue has room.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_front #(
    parameter int MAX_STEPS = sst_pkg::MAX_STEPS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [sst_pkg::FUNC_W-1:0]   func,
    input  wire logic [sst_pkg::INDEX_W-1:0]  note_index,
    input  wire logic [sst_pkg::NOTE_W-1:0]   note_value,
    input  wire logic                         q_full,
    output logic                              q_push,
    output sst_pkg::cmd_t                     q_cmd
);

    logic          cmd_valid_reg, cmd_valid_next;
    sst_pkg::cmd_t cmd_reg, cmd_next;
    logic          accept;
    logic          keep;

    assign q_push   = cmd_valid_reg && !q_full;
    assign q_cmd    = cmd_reg;
    assign in_stall = cmd_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    // a note write past the store is dropped here
    assign keep     = (func != sst_pkg::FUNC_WRITE) || (32'(note_index) < MAX_STEPS);

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        cmd_next       = cmd_reg;
        if (q_push)
        begin
            cmd_valid_next = 1'b0;
        end
        if (accept && keep)
        begin
            cmd_valid_next = 1'b1;
            cmd_next.op    = func;
            cmd_next.index = note_index;
            cmd_next.value = note_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

@@ src/sst_queue.sv @@
// ----------------------------------------------------------------------------
// sst_queue: command queue
// Short first-in first-out queue between the input stage and the player.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_queue #(
    parameter int DEPTH = sst_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire sst_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output sst_pkg::cmd_t      head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sst_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // the input stage must hold its command while the queue is full
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into a full queue");

endmodule

`default_nettype wire

@@ src/sst_divmod.sv @@
// ----------------------------------------------------------------------------
// sst_divmod: bit-serial modulo unit
// Restoring division, one dividend bit per cycle; returns the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_divmod (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sst_pkg::mod_req_t req,
    output sst_pkg::mod_rsp_t      rsp
);

    localparam int DVD_W  = sst_pkg::SPS_W;
    localparam int DVS_W  = sst_pkg::PERIOD_W;
    localparam int ITER_W = $clog2(DVD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;

    // divisor comes from the period table and is never zero
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            iter_next = ITER_W'(DVD_W - 1);
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            rem_next = (trial >= {1'b0, dvs_reg}) ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            if (iter_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                iter_next = iter_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < dvs_reg))
        else $error("remainder not below divisor");

endmodule

`default_nettype wire

@@ src/sst_back.sv @@
// ----------------------------------------------------------------------------
// sst_back: sequence player
// Holds the registers, the note store and the play position; runs one
// command at a time and presents results through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_back #(
    parameter int MAX_STEPS = sst_pkg::MAX_STEPS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [sst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sst_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            q_valid,
    input  wire sst_pkg::cmd_t                   q_head,
    output logic                                 q_pop,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic signed [sst_pkg::SAMPLE_W-1:0]  sample_out,
    output logic                                 is_playing
);

    localparam int IDX_W  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    localparam int CMP_W  = (STEP_W > sst_pkg::SEQ_LEN_W) ? STEP_W : sst_pkg::SEQ_LEN_W;
    localparam int SW     = sst_pkg::SAMPLE_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADV  = 3'd1;
    localparam logic [2:0] S_WRAP = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_MOD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [sst_pkg::SPS_W-1:0]     sps_reg;
    logic [sst_pkg::SEQ_LEN_W-1:0] seq_len_reg;
    logic                          loop_reg;
    logic [sst_pkg::AMP_W-1:0]     amp_reg;

    logic [2:0]                    state_reg, state_next;
    logic                          play_reg, play_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic [sst_pkg::SPS_W-1:0]     count_reg, count_next;
    logic [sst_pkg::PERIOD_W-1:0]  period_reg, period_next;
    logic [SW-1:0]                 res_sample_reg, res_sample_next;
    logic                          res_play_reg, res_play_next;
    logic                          out_valid_reg, out_valid_next;
    logic [SW-1:0]                 out_sample_reg, out_sample_next;
    logic                          out_play_reg, out_play_next;

    logic [sst_pkg::NOTE_W-1:0]    note_mem [MAX_STEPS];
    logic [sst_pkg::NOTE_W-1:0]    rdata_reg;
    logic                          mem_we;
    logic                          rd_en;
    logic [IDX_W-1:0]              rd_addr;
    logic [IDX_W-1:0]              wr_addr;

    logic [CMP_W-1:0]              eff_len;
    logic [SW-1:0]                 amp_pos;
    logic [SW-1:0]                 amp_neg;
    logic                          load_out;
    sst_pkg::mod_req_t             mod_req;
    sst_pkg::mod_rsp_t             mod_rsp;

    sst_divmod u_divmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    assign eff_len = (CMP_W'(seq_len_reg) < CMP_W'(MAX_STEPS)) ?
                     CMP_W'(seq_len_reg) : CMP_W'(MAX_STEPS);
    assign amp_pos = {1'b0, amp_reg};
    assign amp_neg = '0 - amp_pos;
    assign wr_addr = IDX_W'(q_head.index);

    assign out_valid  = out_valid_reg;
    assign sample_out = $signed(out_sample_reg);
    assign is_playing = out_play_reg;

    always_comb
    begin
        state_next       = state_reg;
        play_next        = play_reg;
        step_next        = step_reg;
        count_next       = count_reg;
        period_next      = period_reg;
        res_sample_next  = res_sample_reg;
        res_play_next    = res_play_reg;
        q_pop            = 1'b0;
        mem_we           = 1'b0;
        rd_en            = 1'b0;
        rd_addr          = IDX_W'(step_reg);
        load_out         = 1'b0;
        mod_req.start    = 1'b0;
        mod_req.dividend = count_reg;
        mod_req.divisor  = sst_pkg::PERIOD_ROM[rdata_reg];

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_head.op)
                        sst_pkg::FUNC_WRITE:
                        begin
                            mem_we = 1'b1;
                        end
                        sst_pkg::FUNC_START:
                        begin
                            play_next  = 1'b1;
                            step_next  = '0;
                            count_next = '0;
                        end
                        sst_pkg::FUNC_STOP:
                        begin
                            play_next = 1'b0;
                        end
                        sst_pkg::FUNC_TICK:
                        begin
                            if (play_reg)
                            begin
                                state_next = S_ADV;
                            end
                            else
                            begin
                                res_sample_next = '0;
                                res_play_next   = 1'b0;
                                state_next      = S_OUT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADV:
            begin
                if (count_reg >= sps_reg)
                begin
                    count_next = '0;
                    step_next  = step_reg + 1'b1;
                end
                state_next = S_WRAP;
            end
            S_WRAP:
            begin
                if (CMP_W'(step_reg) >= eff_len)
                begin
                    step_next = '0;
                    if (!loop_reg)
                    begin
                        // end of sequence without loop: silence, count frozen
                        play_next       = 1'b0;
                        res_sample_next = '0;
                        res_play_next   = 1'b0;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = S_READ;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (rdata_reg == '0)
                begin
                    // rest
                    res_sample_next = '0;
                    res_play_next   = 1'b1;
                    count_next      = count_reg + 1'b1;
                    state_next      = S_OUT;
                end
                else
                begin
                    period_next   = sst_pkg::PERIOD_ROM[rdata_reg];
                    mod_req.start = 1'b1;
                    state_next    = S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_rsp.done)
                begin
                    res_sample_next = (mod_rsp.remainder < (period_reg >> 1)) ?
                                      amp_neg : amp_pos;
                    res_play_next   = 1'b1;
                    count_next      = count_reg + 1'b1;
                    state_next      = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && out_stall;
        out_sample_next = out_sample_reg;
        out_play_next   = out_play_reg;
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_sample_next = res_sample_reg;
            out_play_next   = res_play_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            play_reg      <= 1'b0;
            step_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            play_reg      <= play_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg     <= period_next;
        res_sample_reg <= res_sample_next;
        res_play_reg   <= res_play_next;
        out_sample_reg <= out_sample_next;
        out_play_reg   <= out_play_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sps_reg     <= sst_pkg::SPS_RESET;
            seq_len_reg <= sst_pkg::SEQ_LEN_RESET;
            loop_reg    <= sst_pkg::LOOP_RESET;
            amp_reg     <= sst_pkg::AMP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sst_pkg::CFG_SPS:     sps_reg     <= cfg_data[sst_pkg::SPS_W-1:0];
                sst_pkg::CFG_SEQ_LEN: seq_len_reg <= cfg_data[sst_pkg::SEQ_LEN_W-1:0];
                sst_pkg::CFG_LOOP:    loop_reg    <= cfg_data[0];
                sst_pkg::CFG_AMP:     amp_reg     <= cfg_data[sst_pkg::AMP_W-1:0];
                default:              loop_reg    <= loop_reg;
            endcase
        end
    end

    // note store, no reset
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            note_mem[wr_addr] <= q_head.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= note_mem[rd_addr];
        end
    end

    // a sounding sample only ever goes out while playing
    a_sound_implies_playing: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_sample_reg != '0)) |-> out_play_reg)
        else $error("nonzero sample with play flag clear");

    // between commands the position always lies inside the store
    a_step_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (32'(step_reg) < MAX_STEPS))
        else $error("step position outside the note store");

    // the modulo unit is only started from the note read
    a_mod_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD) |-> ($past(state_reg) == S_READ || $past(state_reg) == S_MOD))
        else $error("modulo wait entered without a start");

endmodule

`default_nettype wire

@@ src/step_sequencer_square_tone.sv @@
// ----------------------------------------------------------------------------
// step_sequencer_square_tone: step sequencer with square wave tone output
// Top level: input stage, command queue and sequence player.
// ----------------------------------------------------------------------------
// One input beat is a command: a sample tick, a note write into the step
// store, start or stop. Only a tick returns an output beat, carrying the
// Q1.15 sample (minus or plus amplitude, or zero) and the play flag after
// that tick. An input stage decodes commands and drops note writes beyond
// the store, then a two-entry queue decouples it from the player, so
// commands keep flowing in while the player works or while an output beat
// waits to be taken. A tick that sounds a note runs through the bit-serial
// modulo unit: the in-step sample count (24 bits) is reduced modulo the
// note period one bit per cycle, besides step bookkeeping, store read and
// result hand-off; a rest skips the modulo unit, and a tick that ends a
// non-looping sequence or comes while stopped skips the store read too.
// A tick also waits in the hand-off while the previous output beat is
// held by out_stall. The note store is not cleared at reset: play only
// steps that have been written. The period table is built for a 48 kHz
// sample rate. The user must write registers through the plain write port
// only while the block is idle; the block itself does not enforce it.
// A change takes effect on the next tick.
// ----------------------------------------------------------------------------
`default_nettype none

module step_sequencer_square_tone #(
    parameter int MAX_STEPS   = sst_pkg::MAX_STEPS,
    parameter int QUEUE_DEPTH = sst_pkg::QUEUE_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // command channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [sst_pkg::FUNC_W-1:0]      func,
    input  wire logic [sst_pkg::INDEX_W-1:0]     note_index,
    input  wire logic [sst_pkg::NOTE_W-1:0]      note_value,
    // sample channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic signed [sst_pkg::SAMPLE_W-1:0]  sample_out,
    output logic                                 is_playing,
    // register write port
    input  wire logic                            cfg_we,
    input  wire logic [sst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sst_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic          q_push;
    logic          q_full;
    sst_pkg::cmd_t q_push_cmd;
    logic          q_pop;
    logic          q_valid;
    sst_pkg::cmd_t q_head;

    // decode and filter; holds one command when the queue is full
    sst_front #(
        .MAX_STEPS (MAX_STEPS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .note_index (note_index),
        .note_value (note_value),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_push_cmd)
    );

    sst_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    // player: registers, note store, position, modulo unit, output register
    sst_back #(
        .MAX_STEPS (MAX_STEPS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .is_playing (is_playing)
    );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the step sequencer square tone block
// Fills the note store, walks a short table of commands across extreme
// register settings, then runs randomized phases of note writes, start,
// stop and sample ticks. Every tick is predicted by a cycle-free model
// of the sequencer and each sample beat is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 9;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 125;
    // pad after the last beat so a queued write/start/stop can retire
    localparam int QUIET_PAD       = 64;
    localparam int LONG_HOLD       = 400;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int PLAN_ROWS       = 27;

    // register values after reset
    localparam logic [SPS_W-1:0]     SPS_DEFAULT  = 24'd6000;
    localparam logic [SEQ_LEN_W-1:0] LEN_DEFAULT  = 7'd16;
    localparam logic                 LOOP_DEFAULT = 1'b1;
    localparam logic [AMP_W-1:0]     AMP_DEFAULT  = 15'd3277;

    // period table inputs: 48 kHz rate, A4 = 440 Hz, 2^(k/12) scaled by 1e12
    localparam longint unsigned RATE_HZ  = 64'd48000;
    localparam longint unsigned SCALE_12 = 64'd1000000000000;
    localparam longint unsigned A4_HZ    = 64'd440;
    localparam longint unsigned SEMITONE_E12 [12] = '{
        64'd1000000000000, 64'd1059463094359, 64'd1122462048309, 64'd1189207115003,
        64'd1259921049895, 64'd1334839854170, 64'd1414213562373, 64'd1498307076877,
        64'd1587401051968, 64'd1681792830507, 64'd1781797436281, 64'd1887748625363
    };

    // one output beat
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] level;
        logic                       playing;
    } tone_beat_t;

    // a directed row: either a command beat or a register setting
    typedef struct packed {
        logic                 setup;
        cmd_t                 cmd;
        logic                 typed;
        tone_beat_t           want;
        logic [SPS_W-1:0]     sps;
        logic [SEQ_LEN_W-1:0] len;
        logic                 loop;
        logic [AMP_W-1:0]     amp;
    } plan_row_t;

    // Directed sequence. Expected beats are typed in only where obvious:
    // ticks while stopped, the end of a non-looping sequence, zero amplitude.
    localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
        // stopped after reset: silence, not playing; stop is harmless
        '{1'b0, '{FUNC_TICK,  6'd0,  7'd0},   1'b1, '{16'sd0, 1'b0}, '0, '0, '0, '0},
        '{1'b0, '{FUNC_STOP,  6'd0,  7'd0},   1'b0, '0,              '0, '0, '0, '0},
        '{1'b0, '{FUNC_TICK,  6'd0,  7'd0},   1'b1, '{16'sd0, 1'b0}, '0, '0, '0, '0},
        // A4, a rest, highest note, last index, lowest nonzero note
        '{1'b0, '{FUNC_WRITE, 6'd0,  7'd69},  1'b0, '0,              '0, '0, '0, '0},
        '{1'b0, '{FUNC_WRITE, 6'd1,  7'd0},   1'b0, '0,              '0, '0, '0, '0},
        '{1'b0, '{FUNC_WRITE, 6'd2,  7'd127}, 1'b0, '0,              '0, '0, '0, '0},
        '{1'b0, '{FUNC_WRITE, 6'd63, 7'd127}, 1'b0, '0,              '0, '0, '0, '0},
        '{1'b0, '{FUNC_WRITE, 6'd3,  7'd1},   1'b0, '0,              '0, '0, '0, '0},
        // zero step duration, three steps, no loop, full amplitude
        '{1'b1, '0, 1'b0, '0, 24'd0, 7'd3, 1'b0, 15'd32767},
        '{1'b0, '{FUNC_START, 6'd0,  7'd0},   1'b0, '0,              '0, '0, '0, '0},
        '{1'b0, '{FUNC_TICK,  6'd0,  7'd0},   1'b0, '0,              '0, '0, '0, '0},
        '{1'b0, '{FUNC_TICK,  6'd0,  7'd0},   1'b0, '0,              '0, '0, '0, '0},
        '{1'b0, '{FUNC_TICK,  6'd0,  7'd0},   1'b1, '{16'sd0, 1'b0}, '0, '0, '0, '0},
        '{1'b0, '{FUNC_TICK,  6'd0,  7'd0},   1'b1, '{16'sd0, 1'b0}, '0, '0, '0, '0},
        // zero length wraps every tick; zero amplitude gives silence while playing
        '{1'b1, '0, 1'b0, '0, 24'd2, 7'd0, 1'b1, 15'd0},
        '{1'b0, '{FUNC_START, 6'd0,  7'd0},   1'b0, '0,              '0, '0, '0, '0},
        '{1'b0, '{FUNC_TICK,  6'd0,  7'd0},   1'b1, '{16'sd0, 1'b1}, '0, '0, '0, '0},
        '{1'b0, '{FUNC_TICK,  6'd0,  7'd0},   1'b0, '0,              '0, '0, '0, '0},
        // longest step, length beyond the store, smallest amplitude
        '{1'b1, '0, 1'b0, '0, 24'hFFFFFF, 7'd127, 1'b1, 15'd1},
        '{1'b0, '{FUNC_START, 6'd0,  7'd0},   1'b0, '0,              '0, '0, '0, '0},
        '{1'b0, '{FUNC_TICK,  6'd0,  7'd0},   1'b0, '0,              '0, '0, '0, '0},
        '{1'b0, '{FUNC_TICK,  6'd0,  7'd0},   1'b0, '0,              '0, '0, '0, '0},
        '{1'b0, '{FUNC_TICK,  6'd0,  7'd0},   1'b0, '0,              '0, '0, '0, '0},
        // stop keeps position, tick while stopped is silent
        '{1'b0, '{FUNC_STOP,  6'd0,  7'd0},   1'b0, '0,              '0, '0, '0, '0},
        '{1'b0, '{FUNC_TICK,  6'd0,  7'd0},   1'b1, '{16'sd0, 1'b0}, '0, '0, '0, '0},
        '{1'b0, '{FUNC_START, 6'd0,  7'd0},   1'b0, '0,              '0, '0, '0, '0},
        '{1'b0, '{FUNC_TICK,  6'd0,  7'd0},   1'b0, '0,              '0, '0, '0, '0}
    };

    // ------------------------------------------------------------------------
    // DUT signals; the inputs are driven to known values from time zero
    // ------------------------------------------------------------------------
    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       in_valid   = 1'b0;
    logic                       in_stall;
    logic [FUNC_W-1:0]          func       = FUNC_TICK;
    logic [INDEX_W-1:0]         note_index = '0;
    logic [NOTE_W-1:0]          note_value = '0;
    logic                       out_valid;
    logic                       out_stall  = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       is_playing;
    logic                       cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index  = CFG_SPS;
    logic [CFG_DATA_W-1:0]      cfg_data   = '0;

    // ------------------------------------------------------------------------
    // Sequencer model state and its register copies
    // ------------------------------------------------------------------------
    int unsigned          tone_period [NOTE_COUNT];
    logic [NOTE_W-1:0]    note_store [MAX_STEPS];
    int unsigned          cur_step   = 0;
    logic [SPS_W-1:0]     play_count = '0;
    logic                 play_on    = 1'b0;
    logic [SPS_W-1:0]     set_sps    = SPS_DEFAULT;
    logic [SEQ_LEN_W-1:0] set_len    = LEN_DEFAULT;
    logic                 set_loop   = LOOP_DEFAULT;
    logic [AMP_W-1:0]     set_amp    = AMP_DEFAULT;

    // beats predicted but not yet seen on the sample channel
    tone_beat_t pending_samples [$];

    int  errors        = 0;
    int  samples_taken = 0;
    int  cycles        = 0;
    int  burst_left    = 8;
    bit  offering      = 1'b0;

    step_sequencer_square_tone uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .note_index (note_index),
        .note_value (note_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .is_playing (is_playing),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Note periods in samples, integer only: n - 69 splits into octave and
    // semitone; the octave scales numerator or denominator by a shift.
    initial
    begin : period_table
        longint unsigned num;
        longint unsigned den;
        int              shifted;
        int              octave;
        int              n;
        for (n = 0; n < NOTE_COUNT; n++)
        begin
            shifted = n + 3;
            octave  = shifted / 12 - 6;
            num     = RATE_HZ * SCALE_12;
            den     = A4_HZ * SEMITONE_E12[shifted % 12];
            if (octave < 0)
                num = num << (-octave);
            else
                den = den << octave;
            tone_period[n] = 32'(num / den);
        end
    end

    // ------------------------------------------------------------------------
    // Predictor: applies one accepted command beat to the model, returns 1
    // with the expected sample beat when the command is a tick.
    // ------------------------------------------------------------------------
    function automatic bit advance_sequencer(input cmd_t c, output tone_beat_t beat);
        int unsigned                span;
        int unsigned                period;
        int unsigned                phase;
        logic [NOTE_W-1:0]          note;
        logic signed [SAMPLE_W-1:0] mag;
        bit                         ended;
        beat  = '0;
        ended = 1'b0;
        mag   = {1'b0, set_amp};
        case (c.op)
            FUNC_WRITE:
            begin
                note_store[c.index] = c.value;
                return 1'b0;
            end
            FUNC_START:
            begin
                play_on    = 1'b1;
                cur_step   = 0;
                play_count = '0;
                return 1'b0;
            end
            FUNC_STOP:
            begin
                play_on = 1'b0;
                return 1'b0;
            end
            default: ;
        endcase
        if (play_on)
        begin
            // lengths past the store clamp to its size; zero wraps every tick
            span = (set_len < MAX_STEPS) ? set_len : MAX_STEPS;
            if (play_count >= set_sps)
            begin
                play_count = '0;
                cur_step++;
            end
            if (cur_step >= span)
            begin
                cur_step = 0;
                if (!set_loop)
                begin
                    play_on = 1'b0;
                    ended   = 1'b1;
                end
            end
            if (!ended)
            begin
                note = note_store[cur_step];
                if (note != '0)
                begin
                    period = tone_period[note];
                    phase  = (period != 0) ? play_count % period : play_count;
                    beat.level = (phase < period / 2) ? -mag : mag;
                end
                play_count = play_count + 1'b1;
            end
        end
        beat.playing = play_on;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: offers one command beat and holds it until taken. Bursts of
    // random length with random gaps; valid stays up inside a burst.
    // ------------------------------------------------------------------------
    task automatic issue(input cmd_t c, input bit typed, input tone_beat_t want);
        tone_beat_t beat;
        func       <= c.op;
        note_index <= c.index;
        note_value <= c.value;
        in_valid   <= 1'b1;
        offering    = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (advance_sequencer(c, beat))
            pending_samples.push_back(typed ? want : beat);
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            offering  = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            // now and then a long gap-free burst
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Sender goes quiet until every predicted beat has arrived, then lets
    // trailing commands in the queue retire.
    task automatic await_quiet();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering  = 1'b0;
        end
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (QUIET_PAD) @(posedge clk);
    endtask

    // Writes all four registers on consecutive edges; block must be idle.
    task automatic load_settings(input logic [SPS_W-1:0] sps, input logic [SEQ_LEN_W-1:0] len,
                                 input logic loop, input logic [AMP_W-1:0] amp);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SPS;
        cfg_data  <= CFG_DATA_W'(sps);
        @(posedge clk);
        cfg_index <= CFG_SEQ_LEN;
        cfg_data  <= CFG_DATA_W'(len);
        @(posedge clk);
        cfg_index <= CFG_LOOP;
        cfg_data  <= CFG_DATA_W'(loop);
        @(posedge clk);
        cfg_index <= CFG_AMP;
        cfg_data  <= CFG_DATA_W'(amp);
        @(posedge clk);
        cfg_we   <= 1'b0;
        set_sps  = sps;
        set_len  = len;
        set_loop = loop;
        set_amp  = amp;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        tone_beat_t           no_beat;
        cmd_t                 c;
        logic [SPS_W-1:0]     sps;
        logic [SEQ_LEN_W-1:0] len;
        logic [AMP_W-1:0]     amp;
        int                   i;
        int                   p;
        int                   n;
        int                   r;
        no_beat = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every store entry gets a note first, so play never reads an
        // entry that was never written
        for (i = 0; i < MAX_STEPS; i++)
        begin
            c.op    = FUNC_WRITE;
            c.index = INDEX_W'(i);
            c.value = ($urandom_range(0, 4) == 0) ? '0 : NOTE_W'($urandom);
            issue(c, 1'b0, no_beat);
        end

        for (i = 0; i < PLAN_ROWS; i++)
        begin
            if (DIRECTED_PLAN[i].setup)
            begin
                await_quiet();
                load_settings(DIRECTED_PLAN[i].sps, DIRECTED_PLAN[i].len,
                              DIRECTED_PLAN[i].loop, DIRECTED_PLAN[i].amp);
            end
            else
                issue(DIRECTED_PLAN[i].cmd, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
        end

        // random phases, each with its own register setting
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            await_quiet();
            case ($urandom_range(0, 7))
                0:       sps = '0;
                1:       sps = 24'hFFFFFF;
                2, 3, 4: sps = SPS_W'($urandom_range(1, 6));
                5:       sps = SPS_W'($urandom_range(7, 40));
                6:       sps = SPS_W'($urandom_range(41, 400));
                default: sps = SPS_W'($urandom);
            endcase
            case ($urandom_range(0, 7))
                0:       len = '0;
                1:       len = 7'd1;
                2:       len = 7'd64;
                3:       len = SEQ_LEN_W'($urandom_range(65, 127));
                4:       len = SEQ_LEN_W'($urandom_range(1, 64));
                default: len = SEQ_LEN_W'($urandom_range(2, 6));
            endcase
            case ($urandom_range(0, 5))
                0:       amp = '0;
                1:       amp = 15'h7FFF;
                default: amp = AMP_W'($urandom);
            endcase
            load_settings(sps, len, 1'($urandom_range(0, 1)), amp);

            // mostly play sequences: start, then ticks with the odd edit,
            // restart or stop mixed in
            c = '{FUNC_START, INDEX_W'($urandom), NOTE_W'($urandom)};
            issue(c, 1'b0, no_beat);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                r       = $urandom_range(0, 99);
                c.index = INDEX_W'($urandom);
                c.value = ($urandom_range(0, 4) == 0) ? '0 : NOTE_W'($urandom);
                if (r < 70)
                    c.op = FUNC_TICK;
                else if (r < 82)
                    c.op = FUNC_WRITE;
                else if (r < 91)
                    c.op = FUNC_START;
                else
                    c.op = FUNC_STOP;
                issue(c, 1'b0, no_beat);
                // sender sometimes waits for the sample channel to drain
                if ((p == 1 && n == 60) || $urandom_range(0, 199) == 0)
                    await_quiet();
            end
        end

        await_quiet();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver stall: a pattern picked afresh for each window (none, regular,
    // random, bursty), plus one long hold-off so the queue backs up and
    // the command channel stalls.
    // ------------------------------------------------------------------------
    initial
    begin : sink_stall
        bit held;
        int mode;
        int k;
        held = 1'b0;
        forever
        begin
            if (!held && samples_taken >= 150)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            for (k = 0; k < 64; k++)
            begin
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= (k % 4 == 3);
                    2:       out_stall <= 1'($urandom_range(0, 1));
                    default: out_stall <= (k % 16 < 6);
                endcase
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sample beat checker: each taken beat against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : sample_check
        tone_beat_t exp_beat;
        if (rst_n && out_valid && !out_stall)
        begin
            samples_taken++;
            if (pending_samples.size() == 0)
            begin
                $error("unexpected sample beat: sample_out=%0d is_playing=%0b",
                       sample_out, is_playing);
                errors++;
            end
            else
            begin
                exp_beat = pending_samples.pop_front();
                if (sample_out !== exp_beat.level)
                begin
                    $error("sample_out: expected %0d, actual %0d", exp_beat.level, sample_out);
                    errors++;
                end
                if (is_playing !== exp_beat.playing)
                begin
                    $error("is_playing: expected %0b, actual %0b",
                           exp_beat.playing, is_playing);
                    errors++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
